@@ src/bmts_pkg.sv @@
package bmts_pkg;

  localparam int MaxBlocksDefault   = 512;
  localparam int MaxSelectedDefault = 64;

  localparam int ScoreW   = 32;
  localparam int CountW   = 13;
  localparam int CfgW     = 7;
  localparam int IndexW   = 9;
  localparam int StatusW  = 2;

  localparam logic [12:0] CountMax = 13'd8191;

  // Result status codes.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusEmpty    = 2'd1;
  localparam logic [1:0] StatusNan      = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] RegBlockSize = 1'd0;
  localparam logic [0:0] RegTopK      = 1'd1;

  // Map a float bit pattern to an unsigned key with the same order.
  function automatic logic [31:0] order_key(input logic [31:0] bits);
    logic [31:0] b;
    b = (bits == 32'h8000_0000) ? 32'h0 : bits;
    if (b[31]) begin
      return ~b;
    end
    return b | 32'h8000_0000;
  endfunction

  function automatic logic is_nan(input logic [31:0] bits);
    return (bits[30:23] == 8'hFF) && (bits[22:0] != 23'h0);
  endfunction

endpackage

@@ src/block_max_topk_selector.sv @@
// Block max top-k selector. Scores stream in at one beat per cycle while a run
// is loading, but a used score that is not the first of its block nor a NaN
// holds the input while its block's running maximum is read back from the block
// RAM and, if the score is larger, rewritten. On the last score the block emits
// a status, or in a run without error the final block index, then up to
// top_k-1 other blocks by descending maximum (lower index wins ties). Each
// further result takes one full scan of the stored maxima through the single
// RAM read port. A block that has been picked is marked by overwriting its key
// with zero. No key of a run without a NaN can be zero, so a zero key marks
// only a picked block. The input is not ready during selection. Configuration
// writes are taken at any time.
module block_max_topk_selector #(
  parameter int MaxBlocks   = bmts_pkg::MaxBlocksDefault,
  parameter int MaxSelected = bmts_pkg::MaxSelectedDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bmts_pkg::ScoreW-1:0]  score,
  input  logic [bmts_pkg::CountW-1:0]  visible_count,
  input  logic                         last_score,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bmts_pkg::IndexW-1:0]  block_index,
  output logic [bmts_pkg::StatusW-1:0] status,
  output logic                         last_result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [bmts_pkg::CfgW-1:0]    cfg_data
);

  localparam int AddrW = $clog2(MaxBlocks);
  localparam int BlkW  = $clog2(MaxBlocks + 1);
  localparam int SelW  = $clog2(MaxSelected + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_UPD, S_FIRST, S_SCAN, S_EMIT, S_WAIT
  } state_t;

  state_t state;

  logic [bmts_pkg::CfgW-1:0]   blk_size, top_k, run_block_size;
  logic [bmts_pkg::CountW-1:0] score_counter, visible_limit;
  logic [1:0]                  error_flags;
  logic [BlkW-1:0]             open_blocks;
  logic [bmts_pkg::CfgW-1:0]   in_block_pos;

  // Pending compare for the current block's running maximum.
  logic [31:0] cur_key;

  // Selection state.
  logic [SelW-1:0]  n_sel, n_done;
  logic [AddrW-1:0] scan_addr, prev_addr, best_idx;
  logic [31:0]      best_key;
  logic             found, prev_vld;

  // RAM port signals.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  bmts_ram #(.Width(32), .Depth(MaxBlocks)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
    .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  // Per-beat view of the incoming score.
  logic                        first_beat, used, nan_in, upd_req;
  logic [bmts_pkg::CountW-1:0] lim;
  logic [bmts_pkg::CfgW-1:0]   bs_eff, pos;
  logic [1:0]                  flags;
  logic [BlkW-1:0]             blocks;
  logic [31:0]                 key_in;

  always_comb begin
    first_beat = (score_counter == '0);
    lim        = first_beat ? visible_count : visible_limit;
    bs_eff     = first_beat ? ((blk_size == '0) ? 7'd1 : blk_size) : run_block_size;
    pos        = first_beat ? '0 : in_block_pos;
    flags      = first_beat ? 2'b00 : error_flags;
    blocks     = first_beat ? '0 : open_blocks;
    used       = (score_counter < lim);
    nan_in     = bmts_pkg::is_nan(score);
    key_in     = bmts_pkg::order_key(score);
    upd_req    = used && (pos != '0) && !flags[1] && !nan_in && (blocks != '0);
  end

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;

  // The scan reads either the open block (update) or the next scan entry.
  // A picked block has its key cleared so later scans pass over it.
  always_comb begin
    ram_raddr = (state == S_LOAD) ? AddrW'(blocks - 1'b1) : scan_addr;
    ram_we    = 1'b0;
    ram_waddr = AddrW'(open_blocks - 1'b1);
    ram_wdata = cur_key;
    if (state == S_LOAD && in_valid && used && pos == '0 &&
        blocks < BlkW'(MaxBlocks)) begin
      ram_we    = 1'b1;
      ram_waddr = AddrW'(blocks);
      ram_wdata = key_in;
    end else if (state == S_UPD && ram_rdata < cur_key) begin
      ram_we = 1'b1;
    end else if (state == S_EMIT && found) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = '0;
    end
  end

  logic [BlkW-1:0] last_blk;
  assign last_blk = open_blocks - 1'b1;

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      blk_size       <= 7'd8;
      top_k          <= 7'd64;
      run_block_size <= 7'd8;
      score_counter  <= '0;
      visible_limit  <= '0;
      error_flags    <= '0;
      open_blocks    <= '0;
      in_block_pos   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bmts_pkg::RegBlockSize: blk_size <= cfg_data;
          bmts_pkg::RegTopK:      top_k    <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            visible_limit  <= lim;
            run_block_size <= bs_eff;
            error_flags    <= flags;
            open_blocks    <= blocks;
            in_block_pos   <= pos;
            if (used) begin
              if (nan_in) error_flags[0] <= 1'b1;
              if (pos == '0) begin
                if (blocks >= BlkW'(MaxBlocks)) begin
                  error_flags[1] <= 1'b1;
                end else begin
                  open_blocks <= blocks + 1'b1;
                end
              end else if (upd_req) begin
                cur_key <= key_in;
                state   <= S_UPD;
              end
              in_block_pos <= (pos + 1'b1 >= bs_eff) ? '0 : pos + 1'b1;
            end
            score_counter <= (score_counter < bmts_pkg::CountMax) ?
                             score_counter + 1'b1 : score_counter;
            if (last_score) begin
              score_counter <= '0;
              if (!upd_req) begin
                state <= S_FIRST;
              end
            end
          end
        end
        S_UPD: begin
          // Write-back (larger key only) is combinational here; a last score then
          // moves on to selection.
          state <= (score_counter == '0) ? S_FIRST : S_LOAD;
        end
        S_FIRST: begin
          // First result: status or the final block.
          out_valid   <= 1'b1;
          last_result <= 1'b1;
          block_index <= '0;
          n_done      <= SelW'(1);
          if (open_blocks == '0 || top_k == '0) begin
            status <= bmts_pkg::StatusEmpty;
            n_sel  <= SelW'(1);
          end else if (error_flags[0]) begin
            status <= bmts_pkg::StatusNan;
            n_sel  <= SelW'(1);
          end else if (error_flags[1]) begin
            status <= bmts_pkg::StatusOverflow;
            n_sel  <= SelW'(1);
          end else begin
            status      <= bmts_pkg::StatusOk;
            block_index <= bmts_pkg::IndexW'(last_blk);
            if (BlkW'(top_k) <= open_blocks &&
                32'(top_k) <= 32'(MaxSelected)) begin
              n_sel <= SelW'(top_k);
            end else if (32'(open_blocks) <= 32'(MaxSelected)) begin
              n_sel <= SelW'(open_blocks);
            end else begin
              n_sel <= SelW'(MaxSelected);
            end
            last_result <= (top_k == 7'd1) || (open_blocks == BlkW'(1)) ||
                           (MaxSelected == 1);
          end
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (n_done >= n_sel) begin
              state <= S_LOAD;
            end else begin
              scan_addr <= '0;
              prev_vld  <= 1'b0;
              found     <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // One entry issued per cycle; the previous one's data compares now.
          // A cleared key marks a block that was already picked.
          prev_addr <= scan_addr;
          prev_vld  <= (BlkW'(scan_addr) < last_blk);
          if (prev_vld && ram_rdata != '0 &&
              (!found || ram_rdata > best_key)) begin
            found    <= 1'b1;
            best_key <= ram_rdata;
            best_idx <= prev_addr;
          end
          if (BlkW'(scan_addr) >= last_blk) begin
            state <= S_EMIT;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_EMIT: begin
          if (!found) begin
            state <= S_LOAD;
          end else begin
            block_index <= bmts_pkg::IndexW'(best_idx);
            out_valid   <= 1'b1;
            status      <= bmts_pkg::StatusOk;
            last_result <= (n_done + 1'b1 == n_sel);
            n_done      <= n_done + 1'b1;
            state       <= S_WAIT;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // A non-ok status is always a lone final result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bmts_pkg::StatusOk |-> last_result)
    else $error("status result not final");

  // Input is never taken while a result is pending.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during output");

  // The count of results given never passes the selection size.
  assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |-> n_done <= n_sel)
    else $error("too many results");

endmodule

@@ src/bmts_ram.sv @@
module bmts_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
